// ===== sv/slh_pkg.sv =====
// shared types, constants and codes of the subsampled luma histogram
package slh_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int COMP_W      = 12;
    localparam int SAMPLE_DROP = SAMPLE_W - COMP_W;
    localparam int WEIGHT_W    = 10;
    localparam int PROD_W      = COMP_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int STEP_W      = 4;
    localparam int BIN_W       = 8;
    localparam int COUNT_W     = 32;
    localparam int OPCODE_W    = 2;

    // luma arithmetic
    localparam int ROUND_BIAS  = 512;
    localparam int LUMA_SHIFT  = 10;
    localparam int LUMA_RAW_W  = SUM_W - LUMA_SHIFT;
    localparam int LUMA_MAX    = 4095;
    localparam int LUMA_W      = 12;
    localparam int BIN_SHIFT   = 4;

    // histogram size and output queue
    localparam int BIN_COUNT_DEFAULT = 256;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = WEIGHT_W;
    localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYPASS,
        REG_RED_WEIGHT,
        REG_GREEN_WEIGHT,
        REG_BLUE_WEIGHT,
        REG_COLUMN_STEP,
        REG_ROW_STEP
    } reg_index_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PIXEL,
        OP_READ,
        OP_CLEAR
    } opcode_t;

    // work that reaches the histogram memory
    typedef enum logic [1:0] {
        KIND_COUNT,
        KIND_READ,
        KIND_CLEAR
    } op_kind_t;

    typedef struct packed {
        logic                bypass;
        logic [WEIGHT_W-1:0] red_weight;
        logic [WEIGHT_W-1:0] green_weight;
        logic [WEIGHT_W-1:0] blue_weight;
        logic [STEP_W-1:0]   column_step;
        logic [STEP_W-1:0]   row_step;
    } slh_cfg_t;

    typedef struct packed {
        logic               valid;
        op_kind_t           kind;
        logic [BIN_W-1:0]   bin;
        logic               in_range;
        logic [COUNT_W-1:0] total;
        logic               enabled;
    } slh_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [COUNT_W-1:0] total_pixels;
        logic               stats_enabled;
    } slh_result_t;

    typedef struct packed {
        logic        valid;
        slh_result_t data;
    } slh_push_t;

endpackage

// ===== sv/slh_if.sv =====
// request and result stream interfaces of the luma histogram
interface slh_in_if import slh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
    logic                end_of_line;
    logic [BIN_W-1:0]    bin_index;

    modport source (
        output valid, opcode, red_sample, green_sample, blue_sample, end_of_line, bin_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, red_sample, green_sample, blue_sample, end_of_line, bin_index,
        output ready
    );
endinterface

interface slh_out_if import slh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] total_pixels;
    logic               stats_enabled;

    modport source (
        output valid, bin_count, total_pixels, stats_enabled,
        input  ready
    );
    modport sink (
        input  valid, bin_count, total_pixels, stats_enabled,
        output ready
    );
endinterface

// ===== sv/slh_front.sv =====
// input decode, subsampling phases, pixel total and luma bin pipeline
module slh_front import slh_pkg::*; #(
    parameter int BIN_COUNT = BIN_COUNT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    slh_in_if.sink     request,
    input  logic       space_ok,
    input  slh_cfg_t   cfg,
    output slh_op_t    op,
    output logic [1:0] pend_reads
);

    typedef struct packed {
        logic               valid;
        op_kind_t           kind;
        logic [PROD_W-1:0]  red_prod;
        logic [PROD_W-1:0]  green_prod;
        logic [PROD_W-1:0]  blue_prod;
        logic [BIN_W-1:0]   bin;
        logic               in_range;
        logic [COUNT_W-1:0] total;
        logic               enabled;
    } stage_t;

    logic               accept;
    logic               sampled;
    logic               read_in_range;
    logic [STEP_W-1:0]  col_phase_reg, col_phase_next;
    logic [STEP_W-1:0]  row_phase_reg, row_phase_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    stage_t             s1_reg, s1_next;
    slh_op_t            op_reg, op_next;
    logic [SUM_W-1:0]      luma_sum;
    logic [LUMA_RAW_W-1:0] luma_raw;
    logic [LUMA_W-1:0]     luma;
    logic [BIN_W-1:0]      luma_bin;

    // phase advance with a zero step acting as one
    function automatic logic [STEP_W-1:0] next_phase(
        input logic [STEP_W-1:0] phase,
        input logic [STEP_W-1:0] step
    );
        logic [STEP_W:0] lim;
        logic [STEP_W:0] inc;
        lim = (step == '0) ? (STEP_W+1)'(1) : {1'b0, step};
        inc = {1'b0, phase} + (STEP_W+1)'(1);
        return (inc >= lim) ? '0 : inc[STEP_W-1:0];
    endfunction

    assign accept        = request.valid && space_ok;
    assign request.ready = space_ok;
    assign sampled       = !cfg.bypass && col_phase_reg == '0 && row_phase_reg == '0;
    assign read_in_range = 32'(request.bin_index) < BIN_COUNT;

    // decode one word, update phases and total, form the multiplier stage
    always_comb
    begin
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        total_next     = total_reg;
        s1_next.valid      = 1'b0;
        s1_next.kind       = KIND_READ;
        s1_next.red_prod   = PROD_W'(request.red_sample[SAMPLE_W-1:SAMPLE_DROP])
                             * PROD_W'(cfg.red_weight);
        s1_next.green_prod = PROD_W'(request.green_sample[SAMPLE_W-1:SAMPLE_DROP])
                             * PROD_W'(cfg.green_weight);
        s1_next.blue_prod  = PROD_W'(request.blue_sample[SAMPLE_W-1:SAMPLE_DROP])
                             * PROD_W'(cfg.blue_weight);
        s1_next.bin        = read_in_range ? request.bin_index : '0;
        s1_next.in_range   = read_in_range;
        s1_next.total      = cfg.bypass ? '0 : total_reg;
        s1_next.enabled    = !cfg.bypass;
        if (accept)
        begin
            unique case (opcode_t'(request.opcode))
                OP_PIXEL:
                begin
                    if (request.end_of_line)
                    begin
                        col_phase_next = '0;
                        row_phase_next = next_phase(row_phase_reg, cfg.row_step);
                    end
                    else
                    begin
                        col_phase_next = next_phase(col_phase_reg, cfg.column_step);
                    end
                    if (sampled)
                    begin
                        s1_next.valid = 1'b1;
                        s1_next.kind  = KIND_COUNT;
                        total_next    = (total_reg == '1) ? total_reg
                                                          : total_reg + COUNT_W'(1);
                    end
                end
                OP_READ:
                begin
                    s1_next.valid = 1'b1;
                    s1_next.kind  = KIND_READ;
                end
                OP_CLEAR:
                begin
                    s1_next.valid  = 1'b1;
                    s1_next.kind   = KIND_CLEAR;
                    col_phase_next = '0;
                    row_phase_next = '0;
                    total_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // weighted sum, rounding shift, clip and bin select
    always_comb
    begin
        luma_sum = SUM_W'(s1_reg.red_prod) + SUM_W'(s1_reg.green_prod)
                   + SUM_W'(s1_reg.blue_prod) + SUM_W'(ROUND_BIAS);
        luma_raw = luma_sum[SUM_W-1:LUMA_SHIFT];
        luma     = (luma_raw > LUMA_RAW_W'(LUMA_MAX)) ? LUMA_W'(LUMA_MAX)
                                                      : luma_raw[LUMA_W-1:0];
        luma_bin = luma[LUMA_W-1:BIN_SHIFT];
        if (32'(luma_bin) > BIN_COUNT - 1)
        begin
            luma_bin = BIN_W'(BIN_COUNT - 1);
        end
        op_next.valid    = s1_reg.valid;
        op_next.kind     = s1_reg.kind;
        op_next.bin      = (s1_reg.kind == KIND_COUNT) ? luma_bin : s1_reg.bin;
        op_next.in_range = s1_reg.in_range;
        op_next.total    = s1_reg.total;
        op_next.enabled  = s1_reg.enabled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            total_reg     <= '0;
            s1_reg        <= '0;
            op_reg        <= '0;
        end
        else
        begin
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            total_reg     <= total_next;
            s1_reg        <= s1_next;
            op_reg        <= op_next;
        end
    end

    assign op = op_reg;

    // reads still on their way to the memory stage
    assign pend_reads = 2'(s1_reg.valid && s1_reg.kind == KIND_READ)
                        + 2'(op_reg.valid && op_reg.kind == KIND_READ);

endmodule

// ===== sv/slh_hist.sv =====
// histogram memory with read-modify-write, row valid bits and forwarding
module slh_hist import slh_pkg::*; #(
    parameter int BIN_COUNT = BIN_COUNT_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  slh_op_t   op,
    output slh_push_t push
);

    localparam int LANES  = (BIN_COUNT > 512) ? 4 : 2;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROWS   = (BIN_COUNT + LANES - 1) / LANES;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + LANE_W;
    localparam int LINE_W = LANES * COUNT_W;

    typedef struct packed {
        logic               valid;
        op_kind_t           kind;
        logic [ROW_W-1:0]   row;
        logic [LANE_W-1:0]  lane;
        logic               in_range;
        logic [COUNT_W-1:0] total;
        logic               enabled;
    } stage_t;

    logic [LINE_W-1:0]  mem [ROWS];
    logic [LINE_W-1:0]  rd_line_reg;
    logic [ROWS-1:0]    row_valid_reg;
    logic               fwd_valid_reg;
    logic [ROW_W-1:0]   fwd_row_reg;
    logic [LINE_W-1:0]  fwd_line_reg;
    stage_t             s3_reg;
    logic [ADDR_W-1:0]  op_addr;
    logic               fwd_hit;
    logic               wr_en;
    logic               clr_en;
    logic [LINE_W-1:0]  base_line;
    logic [LINE_W-1:0]  new_line;
    logic [COUNT_W-1:0] lane_val;

    assign op_addr = ADDR_W'(op.bin);

    // memory port: row read for the incoming word, write back from the update stage
    always_ff @(posedge clk)
    begin
        rd_line_reg <= mem[op_addr[ADDR_W-1:LANE_W]];
        if (wr_en)
        begin
            mem[s3_reg.row] <= new_line;
        end
    end

    // stage that sees the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else
        begin
            s3_reg.valid    <= op.valid;
            s3_reg.kind     <= op.kind;
            s3_reg.row      <= op_addr[ADDR_W-1:LANE_W];
            s3_reg.lane     <= op_addr[LANE_W-1:0];
            s3_reg.in_range <= op.in_range;
            s3_reg.total    <= op.total;
            s3_reg.enabled  <= op.enabled;
        end
    end

    // pick the freshest line: last write, stored line, or zero for a cleared row
    always_comb
    begin
        fwd_hit   = fwd_valid_reg && fwd_row_reg == s3_reg.row;
        base_line = fwd_hit ? fwd_line_reg
                            : (row_valid_reg[s3_reg.row] ? rd_line_reg : '0);
        lane_val  = base_line[s3_reg.lane*COUNT_W +: COUNT_W];
        new_line  = base_line;
        new_line[s3_reg.lane*COUNT_W +: COUNT_W] = (lane_val == '1) ? lane_val
                                                   : lane_val + COUNT_W'(1);
        wr_en  = s3_reg.valid && s3_reg.kind == KIND_COUNT;
        clr_en = s3_reg.valid && s3_reg.kind == KIND_CLEAR;
    end

    // row valid bits and write forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_row_reg   <= '0;
            fwd_line_reg  <= '0;
        end
        else
        begin
            if (clr_en)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[s3_reg.row] <= 1'b1;
            end
            fwd_valid_reg <= wr_en;
            fwd_row_reg   <= s3_reg.row;
            fwd_line_reg  <= new_line;
        end
    end

    // result word for a bin read
    always_comb
    begin
        push.valid              = s3_reg.valid && s3_reg.kind == KIND_READ;
        push.data.bin_count     = (s3_reg.enabled && s3_reg.in_range) ? lane_val : '0;
        push.data.total_pixels  = s3_reg.total;
        push.data.stats_enabled = s3_reg.enabled;
    end

endmodule

// ===== sv/slh_out_fifo.sv =====
// output queue that holds result words until the sink takes them
module slh_out_fifo import slh_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slh_push_t            push,
    slh_out_if.source            result,
    output logic [OUT_CNT_W-1:0] level
);

    slh_result_t           entries [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic                  pop;

    assign pop = result.valid && result.ready;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries[wr_ptr_reg] <= push.data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                              : wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                              : rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_reg + OUT_CNT_W'(push.valid) - OUT_CNT_W'(pop);
        end
    end

    assign result.valid         = count_reg != '0;
    assign result.bin_count     = entries[rd_ptr_reg].bin_count;
    assign result.total_pixels  = entries[rd_ptr_reg].total_pixels;
    assign result.stats_enabled = entries[rd_ptr_reg].stats_enabled;
    assign level                = count_reg;

endmodule

// ===== sv/subsampled_luma_histogram.sv =====
// top level: config registers, input credit, front pipeline, histogram memory, output queue
// path of a read word: multiplier stage, luma and bin stage, memory read stage, then the output queue
// throughput: one word per cycle while accepted; the histogram read and write back overlap, forwarding the last write
// acceptance stalls only when the eight-entry output queue plus reads in flight is full
// reset: config to defaults, row valid bits cleared so every bin reads zero, no clearing
// pass; a clear word clears the histogram the same way, also zeroing the pixel total and phases
module subsampled_luma_histogram import slh_pkg::*; #(
    parameter int BIN_COUNT = BIN_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    slh_in_if.sink               request,
    slh_out_if.source            result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CREDIT_W = OUT_CNT_W + 1;

    slh_cfg_t             cfg_reg;
    slh_op_t              op;
    slh_push_t            push;
    logic [1:0]           pend_reads;
    logic [OUT_CNT_W-1:0] level;
    logic                 space_ok;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bypass       <= 1'b0;
            cfg_reg.red_weight   <= '0;
            cfg_reg.green_weight <= '0;
            cfg_reg.blue_weight  <= '0;
            cfg_reg.column_step  <= STEP_RESET;
            cfg_reg.row_step     <= STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BYPASS:       cfg_reg.bypass       <= cfg_data[0];
                REG_RED_WEIGHT:   cfg_reg.red_weight   <= cfg_data[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT: cfg_reg.green_weight <= cfg_data[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:  cfg_reg.blue_weight  <= cfg_data[WEIGHT_W-1:0];
                REG_COLUMN_STEP:  cfg_reg.column_step  <= cfg_data[STEP_W-1:0];
                REG_ROW_STEP:     cfg_reg.row_step     <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // credit: queued words plus reads in flight must leave room for one more
    assign space_ok = (CREDIT_W'(level) + CREDIT_W'(pend_reads) + CREDIT_W'(push.valid))
                      < CREDIT_W'(OUT_DEPTH);

    slh_front #(
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .space_ok   (space_ok),
        .cfg        (cfg_reg),
        .op         (op),
        .pend_reads (pend_reads)
    );

    slh_hist #(
        .BIN_COUNT (BIN_COUNT)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .push  (push)
    );

    slh_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .result (result),
        .level  (level)
    );

    // queue never overflows under the credit scheme
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !(result.valid && result.ready) |-> level < OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    // an accepted bin read reaches the queue after the multiplier, luma and memory stages
    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready && request.opcode == OP_READ |-> ##3 push.valid)
        else $error("bin read lost in pipeline");

    // bypassed statistics report zero counts
    a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.stats_enabled |->
            result.bin_count == '0 && result.total_pixels == '0)
        else $error("nonzero statistics while bypassed");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench of the subsampled luma histogram
module testbench import slh_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS          = BIN_COUNT_DEFAULT;
    localparam int RANDOM_WORDS  = 900;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    // the opcode that the block ignores
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                eol;
        logic [BIN_W-1:0]    bin;
    } pix_word_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_BUSY,
        RX_CHOKED
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 hold_req;

    slh_in_if  request_if ();
    slh_out_if result_if ();

    subsampled_luma_histogram u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // histogram state as the block should hold it
    slh_cfg_t           cfg_now;
    logic [COUNT_W-1:0] hist [BINS];
    logic [COUNT_W-1:0] sampled_total;
    logic [STEP_W-1:0]  col_phase;
    logic [STEP_W-1:0]  row_phase;

    pix_word_t   pending_words [$];
    slh_result_t reads_due [$];
    int          words_queued = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    logic [BIN_W-1:0] recent_bin = '0;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [STEP_W-1:0] phase_next(input logic [STEP_W-1:0] ph,
                                                     input logic [STEP_W-1:0] st);
        int span;
        span = (st == '0) ? 1 : int'(st);
        return (int'(ph) + 1 >= span) ? '0 : ph + 1'b1;
    endfunction

    // rounded weighted sum of the top 12 bits, clipped, then one bin per 16 luma steps
    function automatic logic [BIN_W-1:0] luma_bin(input logic [SAMPLE_W-1:0] r,
                                                  input logic [SAMPLE_W-1:0] g,
                                                  input logic [SAMPLE_W-1:0] b);
        logic [31:0] y;
        y = (32'(r >> SAMPLE_DROP) * cfg_now.red_weight
             + 32'(g >> SAMPLE_DROP) * cfg_now.green_weight
             + 32'(b >> SAMPLE_DROP) * cfg_now.blue_weight
             + ROUND_BIAS) >> LUMA_SHIFT;
        if (y > LUMA_MAX)
            y = LUMA_MAX;
        return y[LUMA_W-1:BIN_SHIFT];
    endfunction

    function automatic void clear_histogram();
        foreach (hist[i])
            hist[i] = '0;
        sampled_total = '0;
        col_phase     = '0;
        row_phase     = '0;
    endfunction

    // apply one accepted word to the histogram state, queue the read result
    function automatic void update_histogram(input pix_word_t w);
        logic [BIN_W-1:0] b;
        slh_result_t      res;
        if (w.op == OP_PIXEL) begin
            if (!cfg_now.bypass && col_phase == '0 && row_phase == '0) begin
                b             = luma_bin(w.red, w.green, w.blue);
                hist[b]       = sat_inc(hist[b]);
                sampled_total = sat_inc(sampled_total);
            end
            if (w.eol) begin
                col_phase = '0;
                row_phase = phase_next(row_phase, cfg_now.row_step);
            end
            else
                col_phase = phase_next(col_phase, cfg_now.column_step);
        end
        else if (w.op == OP_READ) begin
            res.stats_enabled = !cfg_now.bypass;
            res.bin_count     = cfg_now.bypass ? '0 : hist[w.bin];
            res.total_pixels  = cfg_now.bypass ? '0 : sampled_total;
            reads_due = {reads_due, res};
        end
        else if (w.op == OP_CLEAR)
            clear_histogram();
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        pix_word_t seen;
        pix_word_t nxt;
        if (!rst_n) begin
            request_if.valid        <= 1'b0;
            request_if.opcode       <= OP_PIXEL;
            request_if.red_sample   <= '0;
            request_if.green_sample <= '0;
            request_if.blue_sample  <= '0;
            request_if.end_of_line  <= 1'b0;
            request_if.bin_index    <= '0;
            burst_left              <= 0;
            gap_left                <= 0;
        end
        else begin
            if (request_if.valid && request_if.ready) begin
                seen.op    = request_if.opcode;
                seen.red   = request_if.red_sample;
                seen.green = request_if.green_sample;
                seen.blue  = request_if.blue_sample;
                seen.eol   = request_if.end_of_line;
                seen.bin   = request_if.bin_index;
                update_histogram(seen);
            end
            if (!request_if.valid || request_if.ready) begin
                if (gap_left != 0) begin
                    gap_left         <= gap_left - 1;
                    request_if.valid <= 1'b0;
                end
                else if (pending_words.size() != 0) begin
                    nxt = pending_words.pop_front();
                    request_if.valid        <= 1'b1;
                    request_if.opcode       <= nxt.op;
                    request_if.red_sample   <= nxt.red;
                    request_if.green_sample <= nxt.green;
                    request_if.blue_sample  <= nxt.blue;
                    request_if.end_of_line  <= nxt.eol;
                    request_if.bin_index    <= nxt.bin;
                    if (burst_left <= 1) begin
                        // now and then a long burst with no gap at all
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    request_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks each result word, stalls on a changing pattern
    rx_mode_t rx_mode;
    int       rx_left;

    always @(posedge clk or negedge rst_n)
    begin
        slh_result_t want;
        logic        take;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            rx_mode         <= RX_FREE;
            rx_left         <= 0;
        end
        else begin
            if (result_if.valid && result_if.ready) begin
                if (reads_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result word: bin_count %0d total %0d enabled %0b",
                                 result_if.bin_count, result_if.total_pixels,
                                 result_if.stats_enabled);
                end
                else begin
                    want = reads_due.pop_front();
                    if (result_if.bin_count !== want.bin_count
                        || result_if.total_pixels !== want.total_pixels
                        || result_if.stats_enabled !== want.stats_enabled) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result mismatch: bin_count %0d/%0d total %0d/%0d %s",
                                     want.bin_count, result_if.bin_count,
                                     want.total_pixels, result_if.total_pixels,
                                     $sformatf("enabled %0b/%0b (expected/actual)",
                                               want.stats_enabled, result_if.stats_enabled));
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_left <= $urandom_range(8, 64);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FREE: take = 1'b1;
                RX_BUSY: take = ($urandom_range(0, 3) != 0);
                default: take = ($urandom_range(0, 3) == 0);
            endcase
            result_if.ready <= take && (hold_left == 0);
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void queue_word(input logic [OPCODE_W-1:0] op,
                                       input logic [SAMPLE_W-1:0] r,
                                       input logic [SAMPLE_W-1:0] g,
                                       input logic [SAMPLE_W-1:0] b,
                                       input logic eol,
                                       input logic [BIN_W-1:0] bin);
        pix_word_t w;
        w.op    = op;
        w.red   = r;
        w.green = g;
        w.blue  = b;
        w.eol   = eol;
        w.bin   = bin;
        if (op == OP_PIXEL)
            recent_bin = luma_bin(r, g, b);
        pending_words = {pending_words, w};
        words_queued++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly a bin that was just hit, sometimes any bin
    function automatic logic [BIN_W-1:0] read_target();
        return ($urandom_range(0, 9) < 7) ? recent_bin : BIN_W'($urandom_range(0, BINS - 1));
    endfunction

    // wait until nothing is queued, offered or owed, then let the pipeline empty
    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || request_if.valid || reads_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BYPASS:       cfg_now.bypass       = val[0];
            REG_RED_WEIGHT:   cfg_now.red_weight   = val[WEIGHT_W-1:0];
            REG_GREEN_WEIGHT: cfg_now.green_weight = val[WEIGHT_W-1:0];
            REG_BLUE_WEIGHT:  cfg_now.blue_weight  = val[WEIGHT_W-1:0];
            REG_COLUMN_STEP:  cfg_now.column_step  = val[STEP_W-1:0];
            REG_ROW_STEP:     cfg_now.row_step     = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic bypass,
                                input logic [WEIGHT_W-1:0] wr,
                                input logic [WEIGHT_W-1:0] wg,
                                input logic [WEIGHT_W-1:0] wb,
                                input logic [STEP_W-1:0] cs,
                                input logic [STEP_W-1:0] rs);
        wait_drained();
        write_reg(REG_BYPASS, CFG_W'(bypass));
        write_reg(REG_RED_WEIGHT, wr);
        write_reg(REG_GREEN_WEIGHT, wg);
        write_reg(REG_BLUE_WEIGHT, wb);
        write_reg(REG_COLUMN_STEP, CFG_W'(cs));
        write_reg(REG_ROW_STEP, CFG_W'(rs));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return WEIGHT_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] rand_step();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 4'd1;
            2:       return 4'd15;
            default: return STEP_W'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly a clear first, then a frame of rows ended by end_of_line, reads sprinkled in, reads at the end
    task automatic push_frame();
        int rows;
        int len;
        if ($urandom_range(0, 4) != 0)
            queue_word(OP_CLEAR, rand_sample(), rand_sample(), rand_sample(),
                       1'($urandom_range(0, 1)), BIN_W'($urandom_range(0, 255)));
        rows = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 6);
        for (int r = 0; r < rows; r++) begin
            len = $urandom_range(1, 20);
            for (int c = 0; c < len; c++) begin
                queue_word(OP_PIXEL, rand_sample(), rand_sample(), rand_sample(),
                           c == len - 1, BIN_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    queue_word(OP_READ, rand_sample(), rand_sample(), rand_sample(),
                               1'($urandom_range(0, 1)), read_target());
            end
        end
        repeat ($urandom_range(3, 10))
            queue_word(OP_READ, rand_sample(), rand_sample(), rand_sample(),
                       1'($urandom_range(0, 1)), read_target());
    endtask

    // any opcode, any end_of_line
    task automatic push_noise();
        repeat ($urandom_range(20, 50))
            queue_word(OPCODE_W'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                       rand_sample(), 1'($urandom_range(0, 1)), BIN_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase_no;
        int stop_at;
        logic [BIN_W-1:0] mid_bin;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BYPASS;
        cfg_data  = '0;
        hold_req  = 1'b0;
        cfg_now = '{bypass: 1'b0, red_weight: '0, green_weight: '0, blue_weight: '0,
                    column_step: STEP_RESET, row_step: STEP_RESET};
        clear_histogram();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults after reset: empty histogram, zero weights put everything in bin 0
        queue_word(OP_READ, '0, '0, '0, 1'b0, '0);
        queue_word(OP_PIXEL, '0, '0, '0, 1'b0, '0);
        queue_word(OP_READ, '1, '1, '1, 1'b1, '0);

        // full weights, every pixel sampled: clip to the top bin, ignored low bits
        program_regs(1'b0, '1, '1, '1, 4'd1, 4'd1);
        queue_word(OP_PIXEL, '1, '1, '1, 1'b0, '1);
        queue_word(OP_PIXEL, 16'h000F, 16'h000F, 16'h000F, 1'b0, '0);
        queue_word(OP_PIXEL, 16'h0010, '0, '0, 1'b0, '0);
        queue_word(OP_UNUSED, '1, '1, '1, 1'b1, '1);
        queue_word(OP_PIXEL, '1, '1, '1, 1'b1, '0);
        queue_word(OP_READ, '0, '0, '0, 1'b0, BIN_W'(BINS - 1));
        queue_word(OP_READ, '0, '0, '0, 1'b0, '0);

        // zero steps act as one; clear empties bins and total
        program_regs(1'b0, 10'd306, 10'd601, 10'd117, 4'd0, 4'd0);
        queue_word(OP_PIXEL, 16'h8000, 16'h4000, 16'hC000, 1'b1, '0);
        mid_bin = recent_bin;
        queue_word(OP_READ, '0, '0, '0, 1'b0, mid_bin);
        queue_word(OP_CLEAR, '0, '0, '0, 1'b0, '0);
        queue_word(OP_READ, '0, '0, '0, 1'b0, mid_bin);

        // bypass: pixel not counted, reads return zero with stats disabled
        program_regs(1'b1, 10'd306, 10'd601, 10'd117, 4'd0, 4'd0);
        queue_word(OP_PIXEL, 16'h8000, 16'h4000, 16'hC000, 1'b0, '0);
        queue_word(OP_READ, '0, '0, '0, 1'b0, mid_bin);
        program_regs(1'b0, 10'd306, 10'd601, 10'd117, 4'd15, 4'd15);
        queue_word(OP_PIXEL, 16'h8000, 16'h4000, 16'hC000, 1'b0, '0);
        queue_word(OP_READ, '0, '0, '0, 1'b0, mid_bin);

        // random phases, each with its own register setting
        stop_at  = words_queued + RANDOM_WORDS;
        phase_no = 0;
        while (words_queued < stop_at) begin
            phase_no++;
            program_regs(($urandom_range(0, 5) == 0), rand_weight(), rand_weight(),
                         rand_weight(), rand_step(), rand_step());
            if (phase_no == 3) begin
                // read-heavy load against a long receiver hold-off
                repeat (60) begin
                    queue_word(OP_PIXEL, rand_sample(), rand_sample(), rand_sample(),
                               ($urandom_range(0, 7) == 0), '0);
                    queue_word(OP_READ, '0, '0, '0, 1'b0, read_target());
                end
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
                push_noise();
            else
                push_frame();
        end

        wait_drained();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
